// ===== rtl/cht_pkg.sv =====
// Shared types, constants and helper functions for the compressor thermostat.
// No dependencies; imported by cht_cfg_regs and compressor_hysteresis_thermostat.
package cht_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned TIMER_WIDTH      = 22;

  localparam int unsigned TEMP_W     = 15;
  localparam int unsigned SP_W       = 13;
  localparam int unsigned HYST_W     = 11;
  localparam int unsigned SEC_W      = 12;
  localparam int unsigned OFS_W      = 11;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 3;

  // seconds * ticks comparison width
  localparam int unsigned TPS_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned LIM_W = SEC_W + TPS_W;
  localparam int unsigned CMP_W = (LIM_W > TIMER_WIDTH) ? LIM_W : TIMER_WIDTH;

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT    = 3'd0,
    CFG_HYSTERESIS  = 3'd1,
    CFG_MIN_ON      = 3'd2,
    CFG_MIN_OFF     = 3'd3,
    CFG_START_DELAY = 3'd4,
    CFG_ROOM_OFFSET = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SP_W-1:0]   setpoint;
    logic        [HYST_W-1:0] hysteresis;
    logic        [SEC_W-1:0]  min_on;
    logic        [SEC_W-1:0]  min_off;
    logic        [SEC_W-1:0]  start_delay;
    logic signed [OFS_W-1:0]  room_offset;
  } cht_cfg_t;

  localparam logic signed [SP_W-1:0]   SETPOINT_RST    = -13'sd300;
  localparam logic        [HYST_W-1:0] HYSTERESIS_RST  = 11'd100;
  localparam logic        [SEC_W-1:0]  MIN_ON_RST      = 12'd120;
  localparam logic        [SEC_W-1:0]  MIN_OFF_RST     = 12'd180;
  localparam logic        [SEC_W-1:0]  START_DELAY_RST = 12'd60;
  localparam logic signed [OFS_W-1:0]  ROOM_OFFSET_RST = 11'sd0;

  function automatic logic [CMP_W-1:0] limit_ticks(input logic [SEC_W-1:0] secs);
    return CMP_W'(secs) * CMP_W'(TICKS_PER_SECOND);
  endfunction

  function automatic logic elapsed(input timer_t cnt, input logic [SEC_W-1:0] secs);
    return CMP_W'(cnt) >= limit_ticks(secs);
  endfunction

endpackage

// ===== rtl/cht_cfg_regs.sv =====
// Configuration register bank for the compressor thermostat.
// Depends on cht_pkg for register indexes, reset values and the config struct.
module cht_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cht_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cht_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output cht_pkg::cht_cfg_t              cfg_o
);
  import cht_pkg::*;

  cht_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint    <= SETPOINT_RST;
      cfg_q.hysteresis  <= HYSTERESIS_RST;
      cfg_q.min_on      <= MIN_ON_RST;
      cfg_q.min_off     <= MIN_OFF_RST;
      cfg_q.start_delay <= START_DELAY_RST;
      cfg_q.room_offset <= ROOM_OFFSET_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SETPOINT:    cfg_q.setpoint    <= $signed(cfg_data_i[SP_W-1:0]);
        CFG_HYSTERESIS:  cfg_q.hysteresis  <= cfg_data_i[HYST_W-1:0];
        CFG_MIN_ON:      cfg_q.min_on      <= cfg_data_i[SEC_W-1:0];
        CFG_MIN_OFF:     cfg_q.min_off     <= cfg_data_i[SEC_W-1:0];
        CFG_START_DELAY: cfg_q.start_delay <= cfg_data_i[SEC_W-1:0];
        CFG_ROOM_OFFSET: cfg_q.room_offset <= $signed(cfg_data_i[OFS_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/compressor_hysteresis_thermostat.sv =====
// Compressor thermostat with hysteresis and anti-short-cycle timing, top level.
// Depends on cht_pkg and cht_cfg_regs.
//
// One item is taken every clock cycle unless a sample waits for the result register:
// an item goes into an input register, is decided by a single pass of adder,
// saturation and compare logic against the compressor state and the two saturating
// tick counters, and a sample transaction then moves from the input register into
// the result register. Tick items update the counters and give no result. The
// result register frees itself in the same cycle it is taken, so full rate holds
// while out_ready_i stays high. Configuration writes are taken in every cycle.
module compressor_hysteresis_thermostat (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cht_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cht_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic signed [cht_pkg::TEMP_W-1:0] room_temp_centi_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           compressor_on_o,
  output logic                           fan_on_o,
  output logic signed [cht_pkg::TEMP_W-1:0] corrected_temp_centi_o
);
  import cht_pkg::*;

  localparam int unsigned DIFF_W = TEMP_W + 2;

  cht_cfg_t cfg;

  cht_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register
  logic                     s1_valid_q;
  logic                     s1_sample_q;
  logic signed [TEMP_W-1:0] s1_temp_q;

  // state
  logic   comp_q, comp_d;
  timer_t since_reset_q, since_reset_d;
  timer_t since_switch_q, since_switch_d;

  // result register
  logic                     out_valid_q;
  logic                     out_comp_q;
  logic signed [TEMP_W-1:0] out_temp_q;

  logic s1_adv, out_free, in_acc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_sample_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // corrected temperature with saturation
  logic signed [TEMP_W:0]   sum;
  logic signed [TEMP_W-1:0] temp_sat;
  logic signed [DIFF_W-1:0] diff, diff2, hyst_pos, hyst_neg;
  logic                     go_on, go_off, switch_now;

  always_comb begin
    sum = (TEMP_W+1)'(s1_temp_q) + (TEMP_W+1)'(cfg.room_offset);
    if (sum[TEMP_W] != sum[TEMP_W-1]) begin
      temp_sat = sum[TEMP_W] ? {1'b1, {(TEMP_W-1){1'b0}}} : {1'b0, {(TEMP_W-1){1'b1}}};
    end else begin
      temp_sat = sum[TEMP_W-1:0];
    end
    diff     = DIFF_W'(temp_sat) - DIFF_W'(cfg.setpoint);
    diff2    = {diff[DIFF_W-2:0], 1'b0};
    hyst_pos = $signed(DIFF_W'(cfg.hysteresis));
    hyst_neg = -hyst_pos;
    go_on    = (diff2 > hyst_pos) && elapsed(since_reset_q, cfg.start_delay)
               && elapsed(since_switch_q, cfg.min_off);
    go_off   = (diff2 < hyst_neg) && elapsed(since_switch_q, cfg.min_on);
    switch_now = comp_q ? go_off : go_on;
  end

  always_comb begin
    comp_d         = comp_q;
    since_reset_d  = since_reset_q;
    since_switch_d = since_switch_q;
    if (s1_adv) begin
      if (!s1_sample_q) begin
        since_reset_d  = (since_reset_q == '1) ? since_reset_q : since_reset_q + 1'b1;
        since_switch_d = (since_switch_q == '1) ? since_switch_q : since_switch_q + 1'b1;
      end else if (switch_now) begin
        comp_d         = !comp_q;
        since_switch_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      comp_q         <= 1'b0;
      since_reset_q  <= '0;
      since_switch_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      comp_q         <= comp_d;
      since_reset_q  <= since_reset_d;
      since_switch_q <= since_switch_d;
      if (s1_adv && s1_sample_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= opcode_i;
      s1_temp_q   <= room_temp_centi_i;
    end
    if (s1_adv && s1_sample_q) begin
      out_comp_q <= comp_d;
      out_temp_q <= temp_sat;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign compressor_on_o        = out_comp_q;
  assign fan_on_o               = out_comp_q;
  assign corrected_temp_centi_o = out_temp_q;

`ifndef NO_ASSERTIONS
  a_switch_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_sample_q && switch_now) |=> (since_switch_q == '0))
    else $error("switch did not clear the switch timer");

  a_state_only_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (comp_q != $past(comp_q)) |-> (out_valid_q && (out_comp_q == comp_q)))
    else $error("compressor state changed without a result transaction");

  a_since_reset_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(since_reset_q) <= since_reset_q)
    else $error("time since reset went backwards");

  a_tick_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_sample_q && out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("tick disturbed a pending result");
`endif

endmodule
